@@ rtl/jgdc_pkg.sv @@
// ----------------------------------------------------------------------------
// Julian day number / Gregorian date converter: shared definitions
// Stage count, range limits, reciprocal constants and the month offset table.
// ----------------------------------------------------------------------------
package jgdc_pkg;

  localparam int NumStages      = 7;
  localparam int DatapathStages = NumStages - 1;

  localparam logic FuncDayToDate = 1'b0;
  localparam logic FuncDateToDay = 1'b1;

  localparam logic [22:0] DayNumberMax = 23'd5373484;
  localparam logic [22:0] GregSwitch   = 23'd2299160;
  localparam logic [13:0] YearMax      = 14'd9999;
  localparam logic [3:0]  MonthMax     = 4'd12;
  localparam logic [23:0] DayNumberBias = 24'd1720997;

  // floor(n / 146097) for n < 2^24
  localparam int          ADivShift = 42;
  localparam logic [24:0] ADivMul   =
    25'(((64'd1 << ADivShift) + 64'd146097 - 64'd1) / 64'd146097);

  // floor(n / 36525) for n < 2^30
  localparam int          DDivShift = 46;
  localparam logic [30:0] DDivMul   =
    31'(((64'd1 << DDivShift) + 64'd36525 - 64'd1) / 64'd36525);

  // floor(y / 100) and floor(y / 400) for y < 2^14
  localparam int          C100Shift = 21;
  localparam logic [14:0] C100Mul   =
    15'(((64'd1 << C100Shift) + 64'd100 - 64'd1) / 64'd100);
  localparam int          C400Shift = 23;
  localparam logic [14:0] C400Mul   =
    15'(((64'd1 << C400Shift) + 64'd400 - 64'd1) / 64'd400);

  // floor(30.6001 * k)
  function automatic logic [8:0] month_offset(input logic [3:0] k);
    logic [8:0] res;
    case (k)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd30;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd91;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd183;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd244;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd336;
      4'd12:   res = 9'd367;
      4'd13:   res = 9'd397;
      4'd14:   res = 9'd428;
      4'd15:   res = 9'd459;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

@@ rtl/jgdc_stage_ctrl.sv @@
// ----------------------------------------------------------------------------
// Pipeline stage control
// Per-stage valid bits with a ready chain; bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module jgdc_stage_ctrl import jgdc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [NumStages-1:0] stage_en_o,
  output logic [NumStages-1:0] stage_valid_o
);

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] stage_ready;

  always_comb begin
    stage_ready[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_ready[k] = !valid_q[k] || stage_ready[k+1];
    end
  end

  always_comb begin
    valid_d[0] = stage_ready[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = stage_ready[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o    = stage_ready[0];
  assign out_valid_o   = valid_q[NumStages-1];
  assign stage_en_o    = stage_ready;
  assign stage_valid_o = valid_q;

endmodule

@@ rtl/jgdc_day_to_date.sv @@
// ----------------------------------------------------------------------------
// Day number to date datapath
// Gregorian correction, year and month split by reciprocal multiplies.
// ----------------------------------------------------------------------------
module jgdc_day_to_date import jgdc_pkg::*; (
  input  logic                      clk_i,
  input  logic [DatapathStages-1:0] stage_en_i,
  input  logic [22:0]               day_number_i,
  output logic                      err_o,
  output logic [13:0]               d_o,
  output logic [8:0]                x_o,
  output logic [3:0]                g_o
);

  // stage 0
  logic [24:0] i_x4;
  logic [24:0] n1_full;
  logic [22:0] s0_i_q;
  logic        s0_greg_q, s0_err_q;
  logic [23:0] s0_n1_q;

  // stage 1
  logic [48:0] a_prod;
  logic [22:0] s1_i_q;
  logic        s1_greg_q, s1_err_q;
  logic [6:0]  s1_a_q;

  // stage 2
  logic [23:0] b_sum, b_sel, c_full;
  logic [29:0] n2;
  logic [22:0] s2_c_q;
  logic [29:0] s2_n2_q;
  logic        s2_err_q;

  // stage 3
  logic [60:0] d_prod;
  logic [22:0] s3_c_q;
  logic [13:0] s3_d_q;
  logic        s3_err_q;

  // stage 4
  logic [24:0] e_prod;
  logic [22:0] x_full;
  logic [13:0] s4_d_q;
  logic [8:0]  s4_x_q;
  logic        s4_err_q;

  // stage 5
  logic [3:0]  g;
  logic [13:0] s5_d_q;
  logic [8:0]  s5_x_q;
  logic [3:0]  s5_g_q;
  logic        s5_err_q;

  assign i_x4    = {day_number_i, 2'b00};
  assign n1_full = i_x4 - 25'd7468865;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      s0_i_q    <= day_number_i;
      s0_greg_q <= day_number_i > GregSwitch;
      s0_err_q  <= day_number_i > DayNumberMax;
      s0_n1_q   <= n1_full[23:0];
    end
  end

  assign a_prod = 49'(s0_n1_q) * 49'(ADivMul);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      s1_i_q    <= s0_i_q;
      s1_greg_q <= s0_greg_q;
      s1_err_q  <= s0_err_q;
      s1_a_q    <= a_prod[ADivShift+6:ADivShift];
    end
  end

  assign b_sum  = {1'b0, s1_i_q} + 24'd1 + {17'b0, s1_a_q} - {19'b0, s1_a_q[6:2]};
  assign b_sel  = s1_greg_q ? b_sum : {1'b0, s1_i_q};
  assign c_full = b_sel + 24'd1524;
  assign n2     = 30'(c_full) * 30'd100 - 30'd12210;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      s2_c_q   <= c_full[22:0];
      s2_n2_q  <= n2;
      s2_err_q <= s1_err_q;
    end
  end

  assign d_prod = 61'(s2_n2_q) * 61'(DDivMul);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[3]) begin
      s3_c_q   <= s2_c_q;
      s3_d_q   <= d_prod[DDivShift+13:DDivShift];
      s3_err_q <= s2_err_q;
    end
  end

  assign e_prod = 25'(s3_d_q) * 25'd1461;
  assign x_full = s3_c_q - e_prod[24:2];

  always_ff @(posedge clk_i) begin
    if (stage_en_i[4]) begin
      s4_d_q   <= s3_d_q;
      s4_x_q   <= x_full[8:0];
      s4_err_q <= s3_err_q;
    end
  end

  // month index: highest k with x above floor(30.6001 * k)
  always_comb begin
    g = '0;
    for (int k = 1; k < 16; k++) begin
      if (s4_x_q > month_offset(4'(k))) begin
        g = 4'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[5]) begin
      s5_d_q   <= s4_d_q;
      s5_x_q   <= s4_x_q;
      s5_g_q   <= g;
      s5_err_q <= s4_err_q;
    end
  end

  assign err_o = s5_err_q;
  assign d_o   = s5_d_q;
  assign x_o   = s5_x_q;
  assign g_o   = s5_g_q;

endmodule

@@ rtl/jgdc_date_to_day.sv @@
// ----------------------------------------------------------------------------
// Date to day number datapath
// Range check, January/February fold, century term and day number sum.
// ----------------------------------------------------------------------------
module jgdc_date_to_day import jgdc_pkg::*; (
  input  logic                      clk_i,
  input  logic [DatapathStages-1:0] stage_en_i,
  input  logic [13:0]               year_i,
  input  logic [3:0]                month_i,
  input  logic [4:0]                day_i,
  output logic                      err_o,
  output logic [22:0]               day_number_o
);

  logic        jan_feb, in_err;
  logic [3:0]  month_adj;

  logic [13:0] s0_y_q;
  logic [8:0]  s0_off_q;
  logic [4:0]  s0_day_q;
  logic        s0_err_q;

  logic [28:0] p100, p400;
  logic [24:0] p1461;
  logic [6:0]  s1_q100_q;
  logic [4:0]  s1_q400_q;
  logic [21:0] s1_y1461_q;
  logic [8:0]  s1_off_q;
  logic [4:0]  s1_day_q;
  logic        s1_err_q;

  logic [23:0] sum;

  logic [22:0] r_q   [2:DatapathStages-1];
  logic        err_q [2:DatapathStages-1];

  assign jan_feb   = (month_i == 4'd1) || (month_i == 4'd2);
  assign in_err    = (year_i == '0) || (year_i > YearMax) || (month_i == '0) ||
                     (month_i > MonthMax) || (day_i == '0);
  assign month_adj = jan_feb ? month_i + 4'd13 : month_i + 4'd1;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      s0_y_q   <= year_i - 14'(jan_feb);
      s0_off_q <= month_offset(month_adj);
      s0_day_q <= day_i;
      s0_err_q <= in_err;
    end
  end

  assign p100  = 29'(s0_y_q) * 29'(C100Mul);
  assign p400  = 29'(s0_y_q) * 29'(C400Mul);
  assign p1461 = 25'(s0_y_q) * 25'd1461;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      s1_q100_q  <= p100[C100Shift+6:C100Shift];
      s1_q400_q  <= p400[C400Shift+4:C400Shift];
      s1_y1461_q <= p1461[23:2];
      s1_off_q   <= s0_off_q;
      s1_day_q   <= s0_day_q;
      s1_err_q   <= s0_err_q;
    end
  end

  assign sum = DayNumberBias + 24'(s1_y1461_q) + 24'(s1_off_q) + 24'(s1_day_q) +
               24'(s1_q400_q) - 24'(s1_q100_q);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      r_q[2]   <= sum[22:0];
      err_q[2] <= s1_err_q || (sum > 24'(DayNumberMax));
    end
    for (int k = 3; k < DatapathStages; k++) begin
      if (stage_en_i[k]) begin
        r_q[k]   <= r_q[k-1];
        err_q[k] <= err_q[k-1];
      end
    end
  end

  assign err_o        = err_q[DatapathStages-1];
  assign day_number_o = r_q[DatapathStages-1];

endmodule

@@ rtl/julian_gregorian_date_converter.sv @@
// ----------------------------------------------------------------------------
// Julian day number / Gregorian date converter
// Day number to Gregorian date, or date to day number, chosen per item.
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_ready_o carries func_i and the fields of one
// direction; output channel out_valid_o/out_ready_i returns year, month and
// day (func 0) or the day number (func 1), the other direction's fields at
// zero. range_error_o flags an input or result outside its range, all other
// fields then zero.
// The pipeline has seven register stages: six stages cover the datapaths,
// one holds the output.
// Throughput is one transfer per cycle while in_ready_o is high.
// Each stage carries a valid bit. When the receiver stalls, the stages fill
// from the output backwards; in_ready_o drops only once all seven hold an
// item, so nothing is dropped or repeated.
// Reset clears the valid bits; the pipeline comes out empty.
// ----------------------------------------------------------------------------
module julian_gregorian_date_converter import jgdc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [22:0]        day_number_in_i,
  input  logic [13:0]        year_in_i,
  input  logic [3:0]         month_in_i,
  input  logic [4:0]         day_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [14:0] year_out_o,
  output logic [3:0]         month_out_o,
  output logic [4:0]         day_out_o,
  output logic [22:0]        day_number_out_o,
  output logic               range_error_o
);

  logic [NumStages-1:0] stage_en, stage_valid;

  logic        dd_err;
  logic [13:0] dd_d;
  logic [8:0]  dd_x;
  logic [3:0]  dd_g;
  logic        dn_err;
  logic [22:0] dn_r;

  logic func_q [DatapathStages];

  logic [8:0]         dy_full;
  logic [3:0]         mo;
  logic signed [14:0] yr;

  logic signed [14:0] year_d, year_q;
  logic [3:0]         month_d, month_q;
  logic [4:0]         day_d, day_q;
  logic [22:0]        dnum_d, dnum_q;
  logic               rerr_d, rerr_q;

  jgdc_stage_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .stage_en_o   (stage_en),
    .stage_valid_o(stage_valid)
  );

  jgdc_day_to_date u_day_to_date (
    .clk_i       (clk_i),
    .stage_en_i  (stage_en[DatapathStages-1:0]),
    .day_number_i(day_number_in_i),
    .err_o       (dd_err),
    .d_o         (dd_d),
    .x_o         (dd_x),
    .g_o         (dd_g)
  );

  jgdc_date_to_day u_date_to_day (
    .clk_i       (clk_i),
    .stage_en_i  (stage_en[DatapathStages-1:0]),
    .year_i      (year_in_i),
    .month_i     (month_in_i),
    .day_i       (day_in_i),
    .err_o       (dn_err),
    .day_number_o(dn_r)
  );

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      func_q[0] <= func_i;
    end
    for (int k = 1; k < DatapathStages; k++) begin
      if (stage_en[k]) begin
        func_q[k] <= func_q[k-1];
      end
    end
  end

  assign dy_full = dd_x - month_offset(dd_g);
  assign mo      = (dd_g < 4'd14) ? dd_g - 4'd1 : dd_g - 4'd13;
  assign yr      = (mo > 4'd2) ? $signed({1'b0, dd_d}) - 15'sd4716
                               : $signed({1'b0, dd_d}) - 15'sd4715;

  always_comb begin
    year_d  = '0;
    month_d = '0;
    day_d   = '0;
    dnum_d  = '0;
    rerr_d  = 1'b0;
    case (func_q[DatapathStages-1])
      FuncDayToDate: begin
        if (dd_err) begin
          rerr_d = 1'b1;
        end else begin
          year_d  = yr;
          month_d = mo;
          day_d   = dy_full[4:0];
        end
      end
      FuncDateToDay: begin
        if (dn_err) begin
          rerr_d = 1'b1;
        end else begin
          dnum_d = dn_r;
        end
      end
      default: begin
        rerr_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[NumStages-1]) begin
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
      dnum_q  <= dnum_d;
      rerr_q  <= rerr_d;
    end
  end

  assign year_out_o       = year_q;
  assign month_out_o      = month_q;
  assign day_out_o        = day_q;
  assign day_number_out_o = dnum_q;
  assign range_error_o    = rerr_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |->
      year_out_o == '0 && month_out_o == '0 && day_out_o == '0 &&
      day_number_out_o == '0)
    else $error("range error result carries non-zero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !range_error_o |->
      (day_number_out_o != '0) != (month_out_o != '0))
    else $error("result populates both or neither direction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> stage_valid == {NumStages{1'b1}} && !out_ready_i)
    else $error("input stalled while a stage is free");

endmodule
